FILE: src/rti_pkg.sv
// Shared widths, register codes, types and arithmetic helpers for the
// ray/triangle intersection pipeline. No dependencies.
`default_nettype none

package rti_pkg;

   // Coordinate format: signed Q16.16
   localparam int COORD_W = 32;
   localparam int FRAC_W  = 16;

   // Derived datapath widths
   localparam int DIFF_W  = COORD_W + 1;            // vertex differences
   localparam int MUL_W   = 2 * DIFF_W;             // one cross-product term
   localparam int CROSS_W = MUL_W + 1;              // cross-product component
   localparam int LO_W    = DIFF_W + 1;             // low slice of a cross component
   localparam int HI_W    = CROSS_W - LO_W;         // high slice of a cross component
   localparam int LOP_W   = LO_W + 1 + DIFF_W;      // low partial product
   localparam int HIP_W   = HI_W + DIFF_W;          // high partial product
   localparam int SUM_W   = CROSS_W + DIFF_W + 2;   // dot product sum
   localparam int DEN_W   = SUM_W - 1;              // magnitude of a dot product
   localparam int QUO_W   = 31;                     // distance bits
   localparam int NUM_W   = DEN_W + FRAC_W;         // scaled numerator
   localparam int CMP_W   = DEN_W + QUO_W;          // divider compare width

   localparam logic [QUO_W-1:0] DIST_MAX = {QUO_W{1'b1}};

   // Stream widths
   localparam int REQ_W = 9 * COORD_W;
   localparam int RSP_W = 32;

   // Front pipeline depth (before the divider)
   localparam int FRONT_STAGES = 8;

   // Register map
   localparam int CSR_AW    = 5;
   localparam int REG_AW    = 3;
   localparam int REG_COUNT = 6;
   localparam logic [REG_AW-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [REG_AW-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [REG_AW-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [REG_AW-1:0] REG_DIR_X    = 3'd3;
   localparam logic [REG_AW-1:0] REG_DIR_Y    = 3'd4;
   localparam logic [REG_AW-1:0] REG_DIR_Z    = 3'd5;

   typedef logic [2:0][DIFF_W-1:0]  rti_vec_type;
   typedef logic [2:0][CROSS_W-1:0] rti_cvec_type;

   // One divider stage: running remainder, divisor, quotient bits so far
   typedef struct packed {
      logic             hit;
      logic             sat;
      logic [NUM_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [QUO_W-1:0] quo;
   } rti_div_type;

   function automatic logic [DIFF_W-1:0] sext_coord(logic [COORD_W-1:0] v);
      return {v[COORD_W-1], v};
   endfunction

   function automatic logic [MUL_W-1:0] smul_diff(logic [DIFF_W-1:0] a,
                                                  logic [DIFF_W-1:0] b);
      logic signed [MUL_W-1:0] r;
      r = $signed(a) * $signed(b);
      return r;
   endfunction

   // Low slice (unsigned) of a cross component times a difference
   function automatic logic [LOP_W-1:0] mul_lo(logic [CROSS_W-1:0] x,
                                               logic [DIFF_W-1:0] y);
      logic signed [LOP_W-1:0] r;
      r = $signed({1'b0, x[LO_W-1:0]}) * $signed(y);
      return r;
   endfunction

   // High slice (signed) of a cross component times a difference
   function automatic logic [HIP_W-1:0] mul_hi(logic [CROSS_W-1:0] x,
                                               logic [DIFF_W-1:0] y);
      logic signed [HIP_W-1:0] r;
      r = $signed(x[CROSS_W-1:LO_W]) * $signed(y);
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: src/rti_div.sv
// Pipelined restoring divider: one quotient bit per stage, bubble-collapsing
// stall chain, output register in the last stage. Depends on rti_pkg and rti_div_core.
`default_nettype none

module rti_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire rti_pkg::rti_div_type in_item,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic                      out_hit,
   output logic [rti_pkg::QUO_W-1:0] out_dist
);

   // Run the quotient bits through the stage chain
   rti_div_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_ready  (in_ready),
      .in_item   (in_item),
      .out_valid (out_valid),
      .out_ready (out_ready),
      .out_hit   (out_hit),
      .out_dist  (out_dist)
   );

endmodule

`default_nettype wire

FILE: src/rti_div_core.sv
// Pipelined restoring divider core: one quotient bit per stage.
// Depends on rti_pkg.
`default_nettype none

module rti_div_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire rti_pkg::rti_div_type in_item,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic                      out_hit,
   output logic [rti_pkg::QUO_W-1:0] out_dist
);

   rti_pkg::rti_div_type st_ff [rti_pkg::QUO_W];
   rti_pkg::rti_div_type st_in [rti_pkg::QUO_W];
   logic [rti_pkg::QUO_W-1:0] vld_ff;
   logic [rti_pkg::QUO_W-1:0] vld_in;
   logic [rti_pkg::QUO_W:0]   load;

   // Stall chain: a stage loads when empty or when its successor loads
   assign load[rti_pkg::QUO_W] = out_ready;
   for (genvar j = 0; j < rti_pkg::QUO_W; j++) begin : g_stage
      localparam int K = rti_pkg::QUO_W - 1 - j;
      rti_pkg::rti_div_type      src;
      logic [rti_pkg::CMP_W-1:0] trial;
      logic                      ge;

      assign load[j] = !vld_ff[j] || load[j+1];

      if (j == 0) begin : g_first
         assign src       = in_item;
         assign vld_in[j] = in_valid;
      end else begin : g_next
         assign src       = st_ff[j-1];
         assign vld_in[j] = vld_ff[j-1];
      end

      // Try the divisor shifted to this quotient bit; subtract if it fits
      always_comb begin
         trial = rti_pkg::CMP_W'(src.den) << K;
         ge    = rti_pkg::CMP_W'(src.rem) >= trial;
         st_in[j]     = src;
         st_in[j].rem = ge ? src.rem - trial[rti_pkg::NUM_W-1:0] : src.rem;
         st_in[j].quo = src.quo | (ge ? (rti_pkg::QUO_W'(1) << K) : '0);
      end

      always_ff @(posedge clock) begin
         if (load[j]) begin
            st_ff[j] <= st_in[j];
         end
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int j = 0; j < rti_pkg::QUO_W; j++) begin
            if (load[j]) begin
               vld_ff[j] <= vld_in[j];
            end
         end
      end
   end

   assign in_ready  = load[0];
   assign out_valid = vld_ff[rti_pkg::QUO_W-1];
   assign out_hit   = st_ff[rti_pkg::QUO_W-1].hit;

   // Drop the quotient on a miss, clamp on overflow
   always_comb begin
      if (!st_ff[rti_pkg::QUO_W-1].hit) begin
         out_dist = '0;
      end else if (st_ff[rti_pkg::QUO_W-1].sat) begin
         out_dist = rti_pkg::DIST_MAX;
      end else begin
         out_dist = st_ff[rti_pkg::QUO_W-1].quo;
      end
   end

endmodule

`default_nettype wire

FILE: src/ray_triangle_intersection_top.sv
// Structure: an accepted req item passes 8 arithmetic stages, then 31 divider
// stages, one distance bit each, on its way to its rsp item.
// Throughput: one triangle per cycle when rsp_tready does not stall; each stage
// holds one item, bubbles collapse under backpressure. Synchronous active-high reset
// clears all valid bits and the ray registers (origin and direction read back 0).
// Depends on rti_pkg and rti_div.
`default_nettype none

module ray_triangle_intersection_top (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // a_x a_y a_z b_x b_y b_z c_x c_y c_z, 32 bits each, lowest first
   input  wire logic [rti_pkg::REQ_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // distance [30:0], zero pad [31]
   output logic [rti_pkg::RSP_W-1:0]      rsp_tdata,
   // hit [0]
   output logic [0:0]                     rsp_tuser,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [rti_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]               csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   localparam int NF = rti_pkg::FRONT_STAGES;

   // ---------------- configuration registers ----------------
   logic [rti_pkg::COORD_W-1:0] cfg_ff [rti_pkg::REG_COUNT];
   logic [rti_pkg::REG_AW-1:0]  reg_idx;
   logic                        reg_wr;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[rti_pkg::CSR_AW-1:2];
   assign reg_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rti_pkg::REG_COUNT; i++) begin
            cfg_ff[i] <= '0;
         end
      end else if (reg_wr && (reg_idx <= rti_pkg::REG_DIR_Z)) begin
         cfg_ff[reg_idx] <= csr_pwdata;
      end
   end

   assign csr_prdata = (reg_idx <= rti_pkg::REG_DIR_Z) ? cfg_ff[reg_idx] : '0;

   // ---------------- stall chain and valid bits ----------------
   logic [NF:0]   load;
   logic [NF-1:0] v_ff;
   logic [NF-1:0] v_in;
   logic          div_ready;

   assign load[NF] = div_ready;
   for (genvar i = 0; i < NF; i++) begin : g_load
      assign load[i] = !v_ff[i] || load[i+1];
   end

   assign v_in       = {v_ff[NF-2:0], req_tvalid};
   assign req_tready = load[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NF; i++) begin
            if (load[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   // ---------------- stage 0: differences ----------------
   rti_pkg::rti_vec_type s0_ff, e10_ff, e20_ff, d0_ff;
   rti_pkg::rti_vec_type s0_in, e10_in, e20_in, d0_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s0_in[i]  = rti_pkg::sext_coord(cfg_ff[rti_pkg::REG_ORIGIN_X + i])
                   - rti_pkg::sext_coord(req_tdata[i*rti_pkg::COORD_W +: rti_pkg::COORD_W]);
         e10_in[i] = rti_pkg::sext_coord(req_tdata[(i+3)*rti_pkg::COORD_W +: rti_pkg::COORD_W])
                   - rti_pkg::sext_coord(req_tdata[i*rti_pkg::COORD_W +: rti_pkg::COORD_W]);
         e20_in[i] = rti_pkg::sext_coord(req_tdata[(i+6)*rti_pkg::COORD_W +: rti_pkg::COORD_W])
                   - rti_pkg::sext_coord(req_tdata[i*rti_pkg::COORD_W +: rti_pkg::COORD_W]);
         d0_in[i]  = rti_pkg::sext_coord(cfg_ff[rti_pkg::REG_DIR_X + i]);
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s0_ff  <= s0_in;
         e10_ff <= e10_in;
         e20_ff <= e20_in;
         d0_ff  <= d0_in;
      end
   end

   // ---------------- stage 1: cross-product terms ----------------
   logic [rti_pkg::MUL_W-1:0] cp1_ff [12];
   logic [rti_pkg::MUL_W-1:0] cp1_in [12];
   rti_pkg::rti_vec_type s1_ff, e11_ff, e21_ff, d1_ff;

   // P = D x E2, Q = S x E1; component i = a[j]*b[k] - a[k]*b[j]
   always_comb begin
      cp1_in[0]  = rti_pkg::smul_diff(d0_ff[1], e20_ff[2]);
      cp1_in[1]  = rti_pkg::smul_diff(d0_ff[2], e20_ff[1]);
      cp1_in[2]  = rti_pkg::smul_diff(d0_ff[2], e20_ff[0]);
      cp1_in[3]  = rti_pkg::smul_diff(d0_ff[0], e20_ff[2]);
      cp1_in[4]  = rti_pkg::smul_diff(d0_ff[0], e20_ff[1]);
      cp1_in[5]  = rti_pkg::smul_diff(d0_ff[1], e20_ff[0]);
      cp1_in[6]  = rti_pkg::smul_diff(s0_ff[1], e10_ff[2]);
      cp1_in[7]  = rti_pkg::smul_diff(s0_ff[2], e10_ff[1]);
      cp1_in[8]  = rti_pkg::smul_diff(s0_ff[2], e10_ff[0]);
      cp1_in[9]  = rti_pkg::smul_diff(s0_ff[0], e10_ff[2]);
      cp1_in[10] = rti_pkg::smul_diff(s0_ff[0], e10_ff[1]);
      cp1_in[11] = rti_pkg::smul_diff(s0_ff[1], e10_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         cp1_ff <= cp1_in;
         s1_ff  <= s0_ff;
         e11_ff <= e10_ff;
         e21_ff <= e20_ff;
         d1_ff  <= d0_ff;
      end
   end

   // ---------------- stage 2: cross products ----------------
   rti_pkg::rti_cvec_type p2_ff, q2_ff, p2_in, q2_in;
   rti_pkg::rti_vec_type  s2_ff, e12_ff, e22_ff, d2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p2_in[i] = {cp1_ff[2*i][rti_pkg::MUL_W-1], cp1_ff[2*i]}
                  - {cp1_ff[2*i+1][rti_pkg::MUL_W-1], cp1_ff[2*i+1]};
         q2_in[i] = {cp1_ff[2*i+6][rti_pkg::MUL_W-1], cp1_ff[2*i+6]}
                  - {cp1_ff[2*i+7][rti_pkg::MUL_W-1], cp1_ff[2*i+7]};
      end
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         p2_ff  <= p2_in;
         q2_ff  <= q2_in;
         s2_ff  <= s1_ff;
         e12_ff <= e11_ff;
         e22_ff <= e21_ff;
         d2_ff  <= d1_ff;
      end
   end

   // ---------------- stage 3: dot-product partial products ----------------
   // det = P.E1 (0..2), tn = Q.E2 (3..5), un = P.S (6..8), vn = Q.D (9..11)
   logic [rti_pkg::LOP_W-1:0] lo3_ff [12];
   logic [rti_pkg::LOP_W-1:0] lo3_in [12];
   logic [rti_pkg::HIP_W-1:0] hi3_ff [12];
   logic [rti_pkg::HIP_W-1:0] hi3_in [12];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lo3_in[i]   = rti_pkg::mul_lo(p2_ff[i], e12_ff[i]);
         hi3_in[i]   = rti_pkg::mul_hi(p2_ff[i], e12_ff[i]);
         lo3_in[i+3] = rti_pkg::mul_lo(q2_ff[i], e22_ff[i]);
         hi3_in[i+3] = rti_pkg::mul_hi(q2_ff[i], e22_ff[i]);
         lo3_in[i+6] = rti_pkg::mul_lo(p2_ff[i], s2_ff[i]);
         hi3_in[i+6] = rti_pkg::mul_hi(p2_ff[i], s2_ff[i]);
         lo3_in[i+9] = rti_pkg::mul_lo(q2_ff[i], d2_ff[i]);
         hi3_in[i+9] = rti_pkg::mul_hi(q2_ff[i], d2_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         lo3_ff <= lo3_in;
         hi3_ff <= hi3_in;
      end
   end

   // ---------------- stage 4: merge partial products ----------------
   logic [rti_pkg::SUM_W-1:0] dp4_ff [12];
   logic [rti_pkg::SUM_W-1:0] dp4_in [12];

   always_comb begin
      for (int i = 0; i < 12; i++) begin
         dp4_in[i] = {{2{hi3_ff[i][rti_pkg::HIP_W-1]}}, hi3_ff[i], {rti_pkg::LO_W{1'b0}}}
                   + {{(rti_pkg::SUM_W - rti_pkg::LOP_W){lo3_ff[i][rti_pkg::LOP_W-1]}},
                      lo3_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (load[4]) begin
         dp4_ff <= dp4_in;
      end
   end

   // ---------------- stage 5: dot-product sums ----------------
   logic [rti_pkg::SUM_W-1:0] det5_ff, tn5_ff, un5_ff, vn5_ff;

   always_ff @(posedge clock) begin
      if (load[5]) begin
         det5_ff <= dp4_ff[0] + dp4_ff[1]  + dp4_ff[2];
         tn5_ff  <= dp4_ff[3] + dp4_ff[4]  + dp4_ff[5];
         un5_ff  <= dp4_ff[6] + dp4_ff[7]  + dp4_ff[8];
         vn5_ff  <= dp4_ff[9] + dp4_ff[10] + dp4_ff[11];
      end
   end

   // ---------------- stage 6: make the determinant positive ----------------
   logic [rti_pkg::SUM_W-1:0] det6_ff, tn6_ff, un6_ff, vn6_ff;
   logic                      zero6_ff;
   logic                      det_neg;

   assign det_neg = det5_ff[rti_pkg::SUM_W-1];

   always_ff @(posedge clock) begin
      if (load[6]) begin
         zero6_ff <= (det5_ff == '0);
         det6_ff  <= det_neg ? -det5_ff : det5_ff;
         tn6_ff   <= det_neg ? -tn5_ff  : tn5_ff;
         un6_ff   <= det_neg ? -un5_ff  : un5_ff;
         vn6_ff   <= det_neg ? -vn5_ff  : vn5_ff;
      end
   end

   // ---------------- stage 7: hit decision, divider setup ----------------
   rti_pkg::rti_div_type      div7_ff, div7_in;
   logic [rti_pkg::SUM_W:0]   uv_sum;
   logic [rti_pkg::NUM_W-1:0] num;

   always_comb begin
      uv_sum = {un6_ff[rti_pkg::SUM_W-1], un6_ff} + {vn6_ff[rti_pkg::SUM_W-1], vn6_ff};
      num    = {tn6_ff[rti_pkg::DEN_W-1:0], {rti_pkg::FRAC_W{1'b0}}};
      div7_in.hit = !zero6_ff
                 && !tn6_ff[rti_pkg::SUM_W-1] && (tn6_ff != '0)
                 && !un6_ff[rti_pkg::SUM_W-1]
                 && !vn6_ff[rti_pkg::SUM_W-1]
                 && (uv_sum <= {1'b0, det6_ff});
      div7_in.sat = rti_pkg::CMP_W'(num)
                 >= {det6_ff[rti_pkg::DEN_W-1:0], {rti_pkg::QUO_W{1'b0}}};
      div7_in.rem = num;
      div7_in.den = det6_ff[rti_pkg::DEN_W-1:0];
      div7_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (load[7]) begin
         div7_ff <= div7_in;
      end
   end

   // ---------------- distance divider ----------------
   logic                      out_hit;
   logic [rti_pkg::QUO_W-1:0] out_dist;

   rti_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v_ff[NF-1]),
      .in_ready  (div_ready),
      .in_item   (div7_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_hit   (out_hit),
      .out_dist  (out_dist)
   );

   assign rsp_tdata = {1'b0, out_dist};
   assign rsp_tuser = out_hit;

endmodule

`default_nettype wire

FILE: src/rti_checker.sv
// Port-level checks for ray_triangle_intersection_top and the bind that
// attaches them. Depends on rti_pkg.
`default_nettype none

module rti_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [rti_pkg::RSP_W-1:0] rsp_tdata,
   input wire logic [0:0]                rsp_tuser,
   input wire logic                      csr_pready
);

   // No result item right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // Hold a stalled result item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result item changed");

   // A miss carries zero distance
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("miss with nonzero distance");

   // Pad bit above the distance stays clear
   a_pad_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[rti_pkg::RSP_W-1])
      else $error("distance pad bit set");

   // Register port never waits
   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("csr_pready low");

endmodule

bind ray_triangle_intersection_top rti_checker u_rti_checker (.*);

`default_nettype wire

FILE: verif/ray_triangle_intersection_top_tb.sv
// Testbench for the ray/triangle intersection pipeline: drives triangles on the
// req stream, ray registers over the csr port, checks rsp items against a local
// exact-arithmetic predictor. Depends on rti_pkg and ray_triangle_intersection_top.
`default_nettype none

module ray_triangle_intersection_top_tb;

   localparam int WIDE_W  = 256;
   localparam int LATENCY = 39;

   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef struct packed {
      logic        hit;
      logic [30:0] distance;
   } hit_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [rti_pkg::REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [rti_pkg::RSP_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [rti_pkg::CSR_AW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   ray_triangle_intersection_top dut (.*);

   // Ray registers as the predictor sees them
   logic [31:0] ray_reg [rti_pkg::REG_COUNT];
   logic [rti_pkg::REQ_W-1:0] tri_queue [$];
   hit_rsp_type hit_expect [$];
   int error_count = 0;
   bit hold_rsp = 1'b0;
   bit no_gaps = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic wide_type widen(logic [31:0] v);
      return wide_type'($signed(v));
   endfunction

   // Exact Moller-Trumbore against the current ray
   function automatic hit_rsp_type trace_triangle(logic [rti_pkg::REQ_W-1:0] t);
      wide_type o[3], d[3], a[3], b[3], c[3], s[3], e1[3], e2[3], p[3], q[3];
      wide_type det, tn, un, vn, n;
      hit_rsp_type r;
      for (int i = 0; i < 3; i++) begin
         o[i] = widen(ray_reg[i]);
         d[i] = widen(ray_reg[3+i]);
         a[i] = widen(t[32*i +: 32]);
         b[i] = widen(t[32*(3+i) +: 32]);
         c[i] = widen(t[32*(6+i) +: 32]);
         s[i] = o[i] - a[i];
         e1[i] = b[i] - a[i];
         e2[i] = c[i] - a[i];
      end
      for (int i = 0; i < 3; i++) begin
         p[i] = d[(i+1)%3] * e2[(i+2)%3] - d[(i+2)%3] * e2[(i+1)%3];
         q[i] = s[(i+1)%3] * e1[(i+2)%3] - s[(i+2)%3] * e1[(i+1)%3];
      end
      det = p[0]*e1[0] + p[1]*e1[1] + p[2]*e1[2];
      tn = q[0]*e2[0] + q[1]*e2[1] + q[2]*e2[2];
      un = p[0]*s[0] + p[1]*s[1] + p[2]*s[2];
      vn = q[0]*d[0] + q[1]*d[1] + q[2]*d[2];
      r = '0;
      if (det != 0) begin
         if (det < 0) begin
            det = -det; tn = -tn; un = -un; vn = -vn;
         end
         r.hit = tn > 0 && un >= 0 && vn >= 0 && un + vn <= det;
      end
      if (r.hit) begin
         n = tn <<< rti_pkg::FRAC_W;
         if (n >= (det <<< 31)) r.distance = rti_pkg::DIST_MAX;
         else r.distance = 31'(n / det);
      end
      return r;
   endfunction

   function automatic int gap_len();
      if (no_gaps) return 0;
      case ($urandom_range(9))
         0: return $urandom_range(40, 8);
         1, 2, 3: return $urandom_range(3, 1);
         default: return 0;
      endcase
   endfunction

   // Drive queued triangles; predict on acceptance
   int req_gap = 0;
   logic req_accepted = 1'b0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_accepted) begin
            hit_expect.push_back(trace_triangle(req_tdata));
            req_gap = gap_len();
         end
         if ((!req_tvalid || req_accepted)) begin
            if (req_gap > 0 || tri_queue.size() == 0) begin
               req_tvalid <= 1'b0;
               if (req_gap > 0) req_gap--;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata <= tri_queue.pop_front();
            end
         end
      end
   end

   always @(posedge clock) req_accepted <= req_tvalid && req_tready;

   // Receiver backpressure; count the long hold here
   int rsp_gap = 0;
   int hold_left = 0;
   bit hold_taken = 1'b0;
   always @(negedge clock) begin
      if (hold_rsp && !hold_taken) begin
         hold_left = 300;
         hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap--;
      end else begin
         rsp_tready <= 1'b1;
         rsp_gap = gap_len();
      end
   end

   // Compare each result with the oldest prediction
   always @(posedge clock) begin
      hit_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (hit_expect.size() == 0) begin
            $display("%0t: unexpected item hit=%0d dist=%h", $time, rsp_tuser[0],
                     rsp_tdata[30:0]);
            error_count++;
         end else begin
            want = hit_expect.pop_front();
            if (rsp_tuser[0] !== want.hit || rsp_tdata[30:0] !== want.distance ||
                rsp_tdata[31] !== 1'b0) begin
               $display("%0t: mismatch expected hit=%0d dist=%h actual hit=%0d dist=%h",
                        $time, want.hit, want.distance, rsp_tuser[0], rsp_tdata);
               error_count++;
            end
         end
      end
   end

   task automatic write_reg(logic [rti_pkg::REG_AW-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= rti_pkg::CSR_AW'(idx) << 2; csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      ray_reg[idx] = val;
   endtask

   task automatic set_ray(logic [31:0] ox, oy, oz, dx, dy, dz);
      write_reg(rti_pkg::REG_ORIGIN_X, ox); write_reg(rti_pkg::REG_ORIGIN_Y, oy);
      write_reg(rti_pkg::REG_ORIGIN_Z, oz); write_reg(rti_pkg::REG_DIR_X, dx);
      write_reg(rti_pkg::REG_DIR_Y, dy); write_reg(rti_pkg::REG_DIR_Z, dz);
   endtask

   task automatic drain();
      while (tri_queue.size() != 0 || req_tvalid || hit_expect.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] fx(int v);
      return 32'(v) << 16;
   endfunction

   function automatic logic [rti_pkg::REQ_W-1:0] make_tri(logic [31:0] v[9]);
      logic [rti_pkg::REQ_W-1:0] t;
      for (int i = 0; i < 9; i++) t[32*i +: 32] = v[i];
      return t;
   endfunction

   // Random coordinate: mostly small, sometimes full range or extreme
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(9))
         0: return $urandom();
         1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return 32'($signed($urandom_range(2000)) - 1000) <<< 12;
      endcase
   endfunction

   // Triangle around the ray: built so many items actually hit
   function automatic logic [rti_pkg::REQ_W-1:0] aimed_tri();
      logic [31:0] v[9];
      int z;
      z = $urandom_range(60) - 10;
      for (int i = 0; i < 9; i++) v[i] = rand_coord();
      if ($urandom_range(3) != 0) begin
         v[2] = fx(z); v[5] = fx(z); v[8] = fx(z);
         v[0] = fx(-$urandom_range(8)); v[1] = fx(-$urandom_range(8));
         v[3] = fx($urandom_range(8)); v[4] = fx(-$urandom_range(8));
         v[6] = fx(-$urandom_range(4)); v[7] = fx($urandom_range(8));
         if ($urandom_range(1)) v[8] = fx(z) + $urandom_range(65535);
      end
      return make_tri(v);
   endfunction

   initial begin
      logic [31:0] v[9];
      for (int i = 0; i < rti_pkg::REG_COUNT; i++) ray_reg[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Zero direction from reset: every triangle is a miss
      v = '{fx(-1), fx(-1), fx(5), fx(1), fx(-1), fx(5), fx(0), fx(1), fx(5)};
      tri_queue.push_back(make_tri(v));
      drain();

      // Ray along +z from origin
      set_ray(0, 0, 0, 0, 0, fx(1));
      tri_queue.push_back(make_tri(v));                      // plain hit
      v[2] = fx(-5); v[5] = fx(-5); v[8] = fx(-5);
      tri_queue.push_back(make_tri(v));                      // behind origin
      v = '{fx(-1), fx(0), fx(0), fx(1), fx(0), fx(5), fx(0), fx(0), fx(9)};
      tri_queue.push_back(make_tri(v));                      // parallel: zero det
      v = '{fx(-1), fx(-1), 1, fx(1), fx(-1), 1, fx(0), fx(1), 1};
      tri_queue.push_back(make_tri(v));                      // tiny t
      v = '{fx(-1), fx(-1), 32'h7FFFFFFF, fx(1), fx(-1), 32'h7FFFFFFF,
            fx(0), fx(1), 32'h7FFFFFFF};
      tri_queue.push_back(make_tri(v));                      // far plane
      v = '{fx(2), fx(2), fx(3), fx(4), fx(2), fx(3), fx(3), fx(4), fx(3)};
      tri_queue.push_back(make_tri(v));                      // off to the side
      v = '{fx(0), fx(0), fx(4), fx(1), fx(0), fx(4), fx(0), fx(1), fx(4)};
      tri_queue.push_back(make_tri(v));                      // hit on a vertex
      for (int i = 0; i < 9; i++) v[i] = 32'h80000000;
      tri_queue.push_back(make_tri(v));                      // degenerate
      for (int i = 0; i < 9; i++) v[i] = 32'hFFFFFFFF << (i % 2);
      tri_queue.push_back(make_tri(v));
      drain();

      // Short direction: saturated distance
      set_ray(0, 0, 0, 0, 0, 1);
      v = '{fx(-1), fx(-1), fx(100), fx(1), fx(-1), fx(100), fx(0), fx(1), fx(100)};
      tri_queue.push_back(make_tri(v));
      drain();

      // Random phases over several rays, extremes included
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_ray(0, 0, 0, 0, 0, fx(1));
            1: set_ray(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                       32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
            2: set_ray(fx(0), fx(0), fx(-3), 32'h00004000, 32'h00002000, fx(2));
            default: set_ray(32'($urandom_range(65535)), 32'($urandom_range(65535)),
                             fx(-$urandom_range(5)), $urandom_range(1) ? $urandom()
                             : 32'($urandom_range(4095)), 32'($urandom_range(4095)),
                             fx($urandom_range(3, 1)));
         endcase
         if (ph == 3) hold_rsp = 1'b1;
         if (ph == 4) no_gaps = 1'b1;
         for (int k = 0; k < 140; k++) begin
            if (ph == 1 || $urandom_range(7) == 0) begin
               for (int i = 0; i < 9; i++) v[i] = $urandom();
               tri_queue.push_back(make_tri(v));
            end else tri_queue.push_back(aimed_tri());
         end
         drain();
         no_gaps = 1'b0;
      end

      if (error_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
